// ===== src/mvsm_pkg.sv =====
// ----------------------------------------------------------------------------
// Multi-voice sample mixer package
// Request and result types, function codes and the voice record layout.
// ----------------------------------------------------------------------------
`default_nettype none

package mvsm_pkg;

  localparam logic [2:0] FN_LOAD  = 3'd0;
  localparam logic [2:0] FN_START = 3'd1;
  localparam logic [2:0] FN_GAIN  = 3'd2;
  localparam logic [2:0] FN_PITCH = 3'd3;
  localparam logic [2:0] FN_STOP  = 3'd4;
  localparam logic [2:0] FN_MIX   = 3'd5;
  localparam logic [2:0] FN_CLEAR = 3'd6;

  localparam logic [19:0] PITCH_MIN = 20'd66;
  localparam logic [19:0] PITCH_MAX = 20'd524288;

  typedef struct packed {
    logic [2:0]         func;
    logic [3:0]         voice_slot;
    logic [11:0]        sample_index;
    logic signed [15:0] sample_value;
    logic [12:0]        length;
    logic [15:0]        gain_left;
    logic [15:0]        gain_right;
    logic               looping;
    logic [19:0]        pitch_step;
  } req_t;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic               status;
  } res_t;

  typedef struct packed {
    logic        looping;
    logic [12:0] length;
    logic [31:0] cursor;
    logic [19:0] pitch;
    logic [15:0] gain_l;
    logic [15:0] gain_r;
  } voice_rec_t;

endpackage

`default_nettype wire

// ===== src/mvsm_in_if.sv =====
// ----------------------------------------------------------------------------
// Mixer request channel
// Valid/ready channel that carries one mixer request.
// ----------------------------------------------------------------------------
`default_nettype none

interface mvsm_in_if
  import mvsm_pkg::*;
;
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/mvsm_out_if.sv =====
// ----------------------------------------------------------------------------
// Mixer result channel
// Valid/ready channel that carries one mixer result.
// ----------------------------------------------------------------------------
`default_nettype none

interface mvsm_out_if
  import mvsm_pkg::*;
;
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/multi_voice_sample_mixer_unit.sv =====
// Load, start, stop and clear go from ST_IDLE straight to ST_FIN; gain and
// pitch updates pass through ST_RMW (read-modify-write of the voice record).
// Mix: each active voice steps through MRD, MCUR, MS1, MS2, MVAL, MGAIN, MACC
// and MWRAP (repeated per cursor wrap); ST_MRD skips idle voices.
// One request is in flight at a time; the next is taken while a result waits.
// Reset makes every voice idle; sample memory contents are kept.
// ----------------------------------------------------------------------------
// Multi-voice sample mixer
// Wavetable voices with linear interpolation, per-channel gains and a
// saturating stereo sum.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_voice_sample_mixer_unit
  import mvsm_pkg::*;
#(
  parameter int unsigned VOICE_COUNT       = 16,
  parameter int unsigned SAMPLES_PER_VOICE = 4096
) (
  input wire logic    clk_i,
  input wire logic    rst_ni,
  mvsm_in_if.sink     in_i,
  mvsm_out_if.source  out_o
);

  localparam int unsigned VW     = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int unsigned CW     = $clog2(VOICE_COUNT + 1);
  localparam int unsigned IW     = $clog2(SAMPLES_PER_VOICE);
  localparam int unsigned SDEPTH = VOICE_COUNT * SAMPLES_PER_VOICE;
  localparam int unsigned AW     = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
  localparam int unsigned RW     = $bits(voice_rec_t);

  typedef enum logic [3:0] {
    ST_IDLE, ST_RMW, ST_MRD, ST_MCUR, ST_MS1, ST_MS2, ST_MVAL,
    ST_MGAIN, ST_MACC, ST_MWRAP, ST_FIN
  } state_e;

  function automatic logic signed [17:0] round16(input logic signed [34:0] n);
    logic [34:0] m;
    begin
      if (n >= 0) begin
        m = (35'(n) + 35'h8000) >> 16;
        round16 = 18'(m);
      end else begin
        m = (35'(-n) + 35'h8000) >> 16;
        round16 = -$signed(18'(m));
      end
    end
  endfunction

  function automatic logic signed [26:0] round8(input logic signed [34:0] n);
    logic [34:0] m;
    begin
      if (n >= 0) begin
        m = (35'(n) + 35'h80) >> 8;
        round8 = 27'(m);
      end else begin
        m = (35'(-n) + 35'h80) >> 8;
        round8 = -$signed(27'(m));
      end
    end
  endfunction

  state_e             state_q;
  logic               active_q [VOICE_COUNT];
  logic [CW-1:0]      vcnt_q;
  req_t               op_q;
  res_t               res_q;
  res_t               out_q;
  logic               out_valid_q;
  voice_rec_t         rec_q;
  logic [32:0]        cur_q;
  logic [IW-1:0]      i1_q;
  logic [15:0]        frac_q;
  logic signed [15:0] s0_q;
  logic signed [34:0] prod_q;
  logic signed [17:0] val_q;
  logic signed [34:0] pl_q;
  logic signed [34:0] pr_q;
  logic signed [31:0] accl_q;
  logic signed [31:0] accr_q;

  logic          accept;
  logic          fin_load;
  req_t          rq;
  logic [VW-1:0] slot_idx;
  logic [VW-1:0] vidx;
  logic          slot_ok;
  logic          slot_act;
  logic          pitch_ok;
  logic          gain_ok;
  logic          len_ok;
  logic          sidx_ok;
  logic          rej;

  logic          s_we;
  logic [AW-1:0] s_addr;
  logic [15:0]   s_rdata;
  logic          v_we;
  logic [VW-1:0] v_addr;
  voice_rec_t    v_wdata;
  logic [RW-1:0] v_rdata;
  voice_rec_t    rd_rec;

  logic [IW-1:0] i0;
  logic [16:0]   i0n;
  logic [IW-1:0] i1;
  logic [AW-1:0] vbase;
  logic [32:0]   end_pos;
  logic signed [31:0] suml;
  logic signed [31:0] sumr;

  assign rq       = in_i.data;
  assign accept   = in_i.valid && in_i.ready;
  assign fin_load = (state_q == ST_FIN) && (!out_valid_q || out_o.ready);
  assign slot_idx = VW'(rq.voice_slot);
  assign vidx     = vcnt_q[VW-1:0];
  assign slot_ok  = 32'(rq.voice_slot) < VOICE_COUNT;
  assign slot_act = slot_ok && active_q[slot_idx];
  assign pitch_ok = (rq.pitch_step >= PITCH_MIN) && (rq.pitch_step <= PITCH_MAX);
  assign gain_ok  = (rq.gain_left != 16'd0) && (rq.gain_right != 16'd0);
  assign len_ok   = (rq.length != 13'd0) && (32'(rq.length) <= SAMPLES_PER_VOICE);
  assign sidx_ok  = 32'(rq.sample_index) < SAMPLES_PER_VOICE;
  assign rd_rec   = voice_rec_t'(v_rdata);
  assign vbase    = AW'(vidx) * AW'(SAMPLES_PER_VOICE);
  assign end_pos  = 33'({rec_q.length, 16'h0000});

  always_comb begin
    case (rq.func)
      FN_LOAD:  rej = !(slot_ok && sidx_ok);
      FN_START: rej = !(slot_ok && len_ok && gain_ok && pitch_ok) || slot_act;
      FN_GAIN:  rej = !(gain_ok && slot_act);
      FN_PITCH: rej = !(pitch_ok && slot_act);
      FN_STOP:  rej = !slot_act;
      FN_MIX:   rej = 1'b0;
      FN_CLEAR: rej = 1'b0;
      default:  rej = 1'b1;
    endcase
  end

  always_comb begin
    i0  = rd_rec.cursor[16 +: IW];
    i0n = 17'(rd_rec.cursor[31:16]) + 17'd1;
    if (i0n < 17'(rd_rec.length)) begin
      i1 = i0n[IW-1:0];
    end else if (rd_rec.looping) begin
      i1 = '0;
    end else begin
      i1 = i0;
    end
  end

  always_comb begin
    s_we   = 1'b0;
    s_addr = vbase + AW'(i0);
    if (state_q == ST_IDLE) begin
      s_we   = accept && (rq.func == FN_LOAD) && !rej;
      s_addr = AW'(slot_idx) * AW'(SAMPLES_PER_VOICE) + AW'(rq.sample_index);
    end else if (state_q == ST_MS1) begin
      s_addr = vbase + AW'(i1_q);
    end
  end

  always_comb begin
    v_we    = 1'b0;
    v_addr  = vidx;
    v_wdata = rec_q;
    case (state_q)
      ST_IDLE: begin
        v_addr  = slot_idx;
        v_we    = accept && (rq.func == FN_START) && !rej;
        v_wdata.looping = rq.looping;
        v_wdata.length  = rq.length;
        v_wdata.cursor  = 32'd0;
        v_wdata.pitch   = rq.pitch_step;
        v_wdata.gain_l  = rq.gain_left;
        v_wdata.gain_r  = rq.gain_right;
      end
      ST_RMW: begin
        v_addr  = VW'(op_q.voice_slot);
        v_we    = 1'b1;
        v_wdata = rd_rec;
        if (op_q.func == FN_GAIN) begin
          v_wdata.gain_l = op_q.gain_left;
          v_wdata.gain_r = op_q.gain_right;
        end else begin
          v_wdata.pitch = op_q.pitch_step;
        end
      end
      ST_MWRAP: begin
        v_we = !(rec_q.looping && (cur_q >= end_pos));
        v_wdata.cursor = cur_q[31:0];
      end
      default: begin
        v_we = 1'b0;
      end
    endcase
  end

  mvsm_ram #(.WIDTH(16), .DEPTH(SDEPTH)) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .addr_i  (s_addr),
    .wdata_i (rq.sample_value),
    .rdata_o (s_rdata)
  );

  mvsm_ram #(.WIDTH(RW), .DEPTH(VOICE_COUNT)) u_voice_ram (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .addr_i  (v_addr),
    .wdata_i (v_wdata),
    .rdata_o (v_rdata)
  );

  assign suml = accl_q + 32'(round8(pl_q));
  assign sumr = accr_q + 32'(round8(pr_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      for (int i = 0; i < VOICE_COUNT; i++) active_q[i] <= 1'b0;
      vcnt_q      <= '0;
      op_q        <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      rec_q       <= '0;
      cur_q       <= '0;
      i1_q        <= '0;
      frac_q      <= '0;
      s0_q        <= '0;
      prod_q      <= '0;
      val_q       <= '0;
      pl_q        <= '0;
      pr_q        <= '0;
      accl_q      <= '0;
      accr_q      <= '0;
    end else begin
      out_valid_q <= fin_load || (out_valid_q && !out_o.ready);
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            op_q  <= rq;
            res_q <= '{left_out: 16'sd0, right_out: 16'sd0, status: rej};
            if (rej) begin
              state_q <= ST_FIN;
            end else begin
              case (rq.func)
                FN_START: begin
                  active_q[slot_idx] <= 1'b1;
                  state_q <= ST_FIN;
                end
                FN_GAIN:  state_q <= ST_RMW;
                FN_PITCH: state_q <= ST_RMW;
                FN_STOP: begin
                  active_q[slot_idx] <= 1'b0;
                  state_q <= ST_FIN;
                end
                FN_CLEAR: begin
                  for (int i = 0; i < VOICE_COUNT; i++) active_q[i] <= 1'b0;
                  state_q <= ST_FIN;
                end
                FN_MIX: begin
                  vcnt_q  <= '0;
                  accl_q  <= '0;
                  accr_q  <= '0;
                  state_q <= ST_MRD;
                end
                default: state_q <= ST_FIN;
              endcase
            end
          end
        end
        ST_RMW: state_q <= ST_FIN;
        ST_MRD: begin
          if (32'(vcnt_q) >= VOICE_COUNT) begin
            res_q.left_out  <= (accl_q > 32'sd32767) ? 16'sd32767 :
                               (accl_q < -32'sd32768) ? -16'sd32768 : 16'(accl_q);
            res_q.right_out <= (accr_q > 32'sd32767) ? 16'sd32767 :
                               (accr_q < -32'sd32768) ? -16'sd32768 : 16'(accr_q);
            state_q <= ST_FIN;
          end else if (active_q[vidx]) begin
            state_q <= ST_MCUR;
          end else begin
            vcnt_q <= vcnt_q + CW'(1);
          end
        end
        ST_MCUR: begin
          rec_q   <= rd_rec;
          cur_q   <= 33'(rd_rec.cursor) + 33'(rd_rec.pitch);
          frac_q  <= rd_rec.cursor[15:0];
          i1_q    <= i1;
          state_q <= ST_MS1;
        end
        ST_MS1: begin
          s0_q    <= $signed(s_rdata);
          state_q <= ST_MS2;
        end
        ST_MS2: begin
          prod_q  <= 35'((18'($signed(s_rdata)) - 18'(s0_q)) * $signed({2'b00, frac_q}));
          state_q <= ST_MVAL;
        end
        ST_MVAL: begin
          val_q   <= round16((35'(s0_q) <<< 16) + prod_q);
          state_q <= ST_MGAIN;
        end
        ST_MGAIN: begin
          pl_q    <= 35'(val_q * $signed({2'b00, rec_q.gain_l}));
          pr_q    <= 35'(val_q * $signed({2'b00, rec_q.gain_r}));
          state_q <= ST_MACC;
        end
        ST_MACC: begin
          accl_q  <= suml;
          accr_q  <= sumr;
          state_q <= ST_MWRAP;
        end
        ST_MWRAP: begin
          if (rec_q.looping && (cur_q >= end_pos)) begin
            cur_q <= cur_q - end_pos;
          end else begin
            if (!rec_q.looping && (cur_q >= end_pos)) begin
              active_q[vidx] <= 1'b0;
            end
            vcnt_q  <= vcnt_q + CW'(1);
            state_q <= ST_MRD;
          end
        end
        ST_FIN: begin
          if (fin_load) begin
            out_q   <= res_q;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_i.ready  = (state_q == ST_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.status |->
      out_o.data.left_out == 16'sd0 && out_o.data.right_out == 16'sd0)
    else $error("rejected result carries nonzero samples");

  a_vcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MRD |-> 32'(vcnt_q) <= VOICE_COUNT)
    else $error("voice counter out of range");

  a_fin_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIN && (!out_valid_q || out_o.ready) |=> out_valid_q)
    else $error("finished result was not presented");

endmodule

`default_nettype wire

// ===== src/mvsm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mvsm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] addr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

`default_nettype wire
